FILE: rtl/pvs_pkg.sv
// ----------------------------------------------------------------------------
// pvs_pkg
// Shared types and constants of the planar velocity saturator.
// ----------------------------------------------------------------------------
package pvs_pkg;

   // Configuration register data width and reset limit (2.0 in Q8.8)
   localparam int PVS_CSR_WIDTH      = 15;
   localparam int PVS_HARD_LIMIT_INT = 2;
   localparam int PVS_Q_FRAC_BITS    = 8;

   // Entries in the queue between front and back
   localparam int PVS_QUEUE_DEPTH = 4;

   typedef enum logic [0:0] {
      CSR_MAX_LINEAR  = 1'b0,
      CSR_MAX_ANGULAR = 1'b1
   } pvs_csr_idx_type;

   // Per-item control: which axis (if any) takes the ratio, and its sign
   typedef struct packed {
      logic scale_x;
      logic scale_y;
      logic scale_neg;
   } pvs_ctl_type;

endpackage

FILE: rtl/pvs_front.sv
// ----------------------------------------------------------------------------
// pvs_front
// Classifies an incoming command: axis magnitudes, larger axis, limit
// checks, clamped values and the division operands for the back end.
// ----------------------------------------------------------------------------
module pvs_front #(
   parameter int VEL_WIDTH = 16
) (
   input  logic signed [VEL_WIDTH-1:0] vel_x,
   input  logic signed [VEL_WIDTH-1:0] vel_y,
   input  logic signed [VEL_WIDTH-1:0] vel_turn,
   input  logic        [VEL_WIDTH-2:0] max_linear,
   input  logic        [VEL_WIDTH-2:0] max_angular,
   output pvs_pkg::pvs_ctl_type         ctl,
   output logic        [VEL_WIDTH-1:0] num,
   output logic        [VEL_WIDTH-1:0] den,
   output logic signed [VEL_WIDTH-1:0] pre_x,
   output logic signed [VEL_WIDTH-1:0] pre_y,
   output logic signed [VEL_WIDTH-1:0] pre_turn
);
   import pvs_pkg::*;

   localparam int VW = VEL_WIDTH;

   logic          neg_x, neg_y, neg_t;
   logic [VW-1:0] mag_x, mag_y, mag_t;
   logic [VW-1:0] lin_lim, ang_lim;
   logic [VW-1:0] lin_neg, ang_neg;
   logic          x_major, x_over, y_over, t_over;

   always_comb begin
      neg_x = vel_x[VW-1];
      neg_y = vel_y[VW-1];
      neg_t = vel_turn[VW-1];
      // most negative input yields 2^(VW-1), which fits unsigned
      mag_x = neg_x ? (~$unsigned(vel_x) + 1'b1) : $unsigned(vel_x);
      mag_y = neg_y ? (~$unsigned(vel_y) + 1'b1) : $unsigned(vel_y);
      mag_t = neg_t ? (~$unsigned(vel_turn) + 1'b1) : $unsigned(vel_turn);

      lin_lim = {1'b0, max_linear};
      ang_lim = {1'b0, max_angular};
      lin_neg = ~lin_lim + 1'b1;
      ang_neg = ~ang_lim + 1'b1;

      // tie goes to y as the larger axis
      x_major = mag_x > mag_y;
      x_over  = mag_x > lin_lim;
      y_over  = mag_y > lin_lim;
      t_over  = mag_t > ang_lim;

      num = x_major ? mag_y : mag_x;
      den = x_major ? mag_x : mag_y;

      pre_x    = x_over ? $signed(neg_x ? lin_neg : lin_lim) : vel_x;
      pre_y    = y_over ? $signed(neg_y ? lin_neg : lin_lim) : vel_y;
      pre_turn = t_over ? $signed(neg_t ? ang_neg : ang_lim) : vel_turn;

      ctl.scale_x   = x_over & ~x_major;
      ctl.scale_y   = y_over & x_major;
      ctl.scale_neg = x_major ? neg_y : neg_x;
   end

endmodule

FILE: rtl/pvs_queue.sv
// ----------------------------------------------------------------------------
// pvs_queue
// Short FIFO between front and back. The back drains the head whenever
// an entry is present; full raises busy toward the command side.
// ----------------------------------------------------------------------------
module pvs_queue #(
   parameter int DATA_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] push_data,
   output logic                  full,
   output logic                  pop_valid,
   output logic [DATA_WIDTH-1:0] pop_data
);
   import pvs_pkg::*;

   localparam int DEPTH = PVS_QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  pop;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop       = pop_valid;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/pvs_back.sv
// ----------------------------------------------------------------------------
// pvs_back
// Pipelined restoring divider for the axis ratio, one quotient bit per
// stage, followed by the limit-times-ratio multiply and the output stage.
// ----------------------------------------------------------------------------
module pvs_back #(
   parameter int VEL_WIDTH       = 16,
   parameter int RATIO_FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  pvs_pkg::pvs_ctl_type        in_ctl,
   input  logic        [VEL_WIDTH-1:0] in_num,
   input  logic        [VEL_WIDTH-1:0] in_den,
   input  logic signed [VEL_WIDTH-1:0] in_pre_x,
   input  logic signed [VEL_WIDTH-1:0] in_pre_y,
   input  logic signed [VEL_WIDTH-1:0] in_pre_turn,
   input  logic        [VEL_WIDTH-2:0] max_linear,
   output logic                        rsp_valid,
   output logic signed [VEL_WIDTH-1:0] rsp_sat_x,
   output logic signed [VEL_WIDTH-1:0] rsp_sat_y,
   output logic signed [VEL_WIDTH-1:0] rsp_sat_turn
);
   import pvs_pkg::*;

   localparam int VW     = VEL_WIDTH;
   localparam int FB     = RATIO_FRAC_BITS;
   localparam int QW     = FB + 1;
   localparam int PROD_W = VW + FB;
   localparam int NST    = FB + 1;

   // divider stages
   logic              st_valid_ff [NST];
   logic              st_valid_in [NST];
   logic [VW-1:0]     st_rem_ff   [NST];
   logic [VW-1:0]     st_rem_in   [NST];
   logic [VW-1:0]     st_den_ff   [NST];
   logic [VW-1:0]     st_den_in   [NST];
   logic [QW-1:0]     st_quo_ff   [NST];
   logic [QW-1:0]     st_quo_in   [NST];
   logic [VW-1:0]     st_px_ff    [NST];
   logic [VW-1:0]     st_px_in    [NST];
   logic [VW-1:0]     st_py_ff    [NST];
   logic [VW-1:0]     st_py_in    [NST];
   logic [VW-1:0]     st_pt_ff    [NST];
   logic [VW-1:0]     st_pt_in    [NST];
   pvs_ctl_type       st_ctl_ff   [NST];
   pvs_ctl_type       st_ctl_in   [NST];

   // multiply stage
   logic              mul_valid_ff;
   logic [PROD_W-1:0] mul_prod_ff, mul_prod_in;
   logic [VW-1:0]     mul_px_ff, mul_py_ff, mul_pt_ff;
   pvs_ctl_type       mul_ctl_ff;

   // output stage
   logic              out_valid_ff;
   logic [VW-1:0]     out_x_ff, out_x_in;
   logic [VW-1:0]     out_y_ff, out_y_in;
   logic [VW-1:0]     out_t_ff;

   logic [VW:0]       trial, diff;
   logic              ge;
   logic [VW-1:0]     scaled_mag, scaled;

   always_comb begin
      // first stage decides the integer bit (set only on a tie)
      ge = in_num >= in_den;
      st_valid_in[0] = in_valid;
      st_rem_in[0]   = ge ? (in_num - in_den) : in_num;
      st_den_in[0]   = in_den;
      st_quo_in[0]   = {{FB{1'b0}}, ge};
      st_px_in[0]    = $unsigned(in_pre_x);
      st_py_in[0]    = $unsigned(in_pre_y);
      st_pt_in[0]    = $unsigned(in_pre_turn);
      st_ctl_in[0]   = in_ctl;
      trial = '0;
      diff  = '0;
      for (int k = 1; k < NST; k++) begin
         trial = {st_rem_ff[k-1], 1'b0};
         diff  = trial - {1'b0, st_den_ff[k-1]};
         ge    = trial >= {1'b0, st_den_ff[k-1]};
         st_valid_in[k] = st_valid_ff[k-1];
         st_rem_in[k]   = ge ? diff[VW-1:0] : trial[VW-1:0];
         st_den_in[k]   = st_den_ff[k-1];
         st_quo_in[k]   = {st_quo_ff[k-1][QW-2:0], ge};
         st_px_in[k]    = st_px_ff[k-1];
         st_py_in[k]    = st_py_ff[k-1];
         st_pt_in[k]    = st_pt_ff[k-1];
         st_ctl_in[k]   = st_ctl_ff[k-1];
      end
   end

   assign mul_prod_in = PROD_W'(max_linear) * PROD_W'(st_quo_ff[NST-1]);

   always_comb begin
      // truncate toward zero on the magnitude, then restore the sign
      scaled_mag = mul_prod_ff[FB +: VW];
      scaled     = mul_ctl_ff.scale_neg ? (~scaled_mag + 1'b1) : scaled_mag;
      out_x_in   = mul_ctl_ff.scale_x ? scaled : mul_px_ff;
      out_y_in   = mul_ctl_ff.scale_y ? scaled : mul_py_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) begin
            st_valid_ff[k] <= 1'b0;
         end
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         st_valid_ff  <= st_valid_in;
         mul_valid_ff <= st_valid_ff[NST-1];
         out_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      st_rem_ff   <= st_rem_in;
      st_den_ff   <= st_den_in;
      st_quo_ff   <= st_quo_in;
      st_px_ff    <= st_px_in;
      st_py_ff    <= st_py_in;
      st_pt_ff    <= st_pt_in;
      st_ctl_ff   <= st_ctl_in;
      mul_prod_ff <= mul_prod_in;
      mul_px_ff   <= st_px_ff[NST-1];
      mul_py_ff   <= st_py_ff[NST-1];
      mul_pt_ff   <= st_pt_ff[NST-1];
      mul_ctl_ff  <= st_ctl_ff[NST-1];
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_t_ff    <= mul_pt_ff;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_sat_x    = $signed(out_x_ff);
   assign rsp_sat_y    = $signed(out_y_ff);
   assign rsp_sat_turn = $signed(out_t_ff);

endmodule

FILE: rtl/planar_velocity_saturator_unit.sv
// ----------------------------------------------------------------------------
// planar_velocity_saturator_unit
// Saturates a planar velocity command (x, y, turn) in signed Q8.8.
//
// Command channel: a command transfers on a rising edge with start high and
// busy low. Commands may follow each other in every cycle; one command per
// cycle is sustained.
// Result channel: rsp_valid marks a result for exactly one cycle; results
// come in command order, one per command. The receiver cannot stall, so
// the pipeline never holds back.
// Pipeline: a command passes through the queue register, RATIO_FRAC_BITS + 1
// divider stages (one ratio bit each), the multiply stage and the output
// register before its result is visible.
// Config channel: csr_ready is always high; index 0 sets max_linear, index
// 1 sets max_angular. Write only while no command is in flight.
// Reset: both limits return to 2.0 and the pipeline empties.
// ----------------------------------------------------------------------------
module planar_velocity_saturator_unit #(
   parameter int VEL_WIDTH       = 16,
   parameter int RATIO_FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [VEL_WIDTH-1:0]         req_vel_x,
   input  logic signed [VEL_WIDTH-1:0]         req_vel_y,
   input  logic signed [VEL_WIDTH-1:0]         req_vel_turn,
   output logic                                rsp_valid,
   output logic signed [VEL_WIDTH-1:0]         rsp_sat_x,
   output logic signed [VEL_WIDTH-1:0]         rsp_sat_y,
   output logic signed [VEL_WIDTH-1:0]         rsp_sat_turn,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  pvs_pkg::pvs_csr_idx_type            csr_index,
   input  logic [pvs_pkg::PVS_CSR_WIDTH-1:0]   csr_wdata
);
   import pvs_pkg::*;

   localparam int VW        = VEL_WIDTH;
   localparam int LIM_W     = VW - 1;
   localparam int CTL_W     = $bits(pvs_ctl_type);
   localparam int QDATA_W   = CTL_W + 5 * VW;
   localparam logic [LIM_W-1:0] LIM_RESET =
      LIM_W'(PVS_HARD_LIMIT_INT << PVS_Q_FRAC_BITS);

   logic [LIM_W-1:0] max_linear_ff, max_linear_in;
   logic [LIM_W-1:0] max_angular_ff, max_angular_in;

   pvs_ctl_type          f_ctl;
   logic [VW-1:0]        f_num, f_den;
   logic signed [VW-1:0] f_pre_x, f_pre_y, f_pre_turn;

   logic                 push, q_full, q_valid;
   logic [QDATA_W-1:0]   q_wdata, q_rdata;

   pvs_ctl_type          b_ctl;
   logic [VW-1:0]        b_num, b_den, b_pre_x, b_pre_y, b_pre_turn;

   assign csr_ready = 1'b1;

   always_comb begin
      max_linear_in  = max_linear_ff;
      max_angular_in = max_angular_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAX_LINEAR:  max_linear_in  = LIM_W'(csr_wdata);
            CSR_MAX_ANGULAR: max_angular_in = LIM_W'(csr_wdata);
            default: begin
               max_linear_in  = max_linear_ff;
               max_angular_in = max_angular_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_linear_ff  <= LIM_RESET;
         max_angular_ff <= LIM_RESET;
      end else begin
         max_linear_ff  <= max_linear_in;
         max_angular_ff <= max_angular_in;
      end
   end

   pvs_front #(
      .VEL_WIDTH (VEL_WIDTH)
   ) u_front (
      .vel_x       (req_vel_x),
      .vel_y       (req_vel_y),
      .vel_turn    (req_vel_turn),
      .max_linear  (max_linear_ff),
      .max_angular (max_angular_ff),
      .ctl         (f_ctl),
      .num         (f_num),
      .den         (f_den),
      .pre_x       (f_pre_x),
      .pre_y       (f_pre_y),
      .pre_turn    (f_pre_turn)
   );

   // transfer into the queue on every accepted command
   assign busy    = q_full;
   assign push    = start & ~q_full;
   assign q_wdata = {f_ctl, f_num, f_den, $unsigned(f_pre_x), $unsigned(f_pre_y),
                     $unsigned(f_pre_turn)};

   pvs_queue #(
      .DATA_WIDTH (QDATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_data  (q_rdata)
   );

   assign {b_ctl, b_num, b_den, b_pre_x, b_pre_y, b_pre_turn} = q_rdata;

   pvs_back #(
      .VEL_WIDTH       (VEL_WIDTH),
      .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (q_valid),
      .in_ctl       (b_ctl),
      .in_num       (b_num),
      .in_den       (b_den),
      .in_pre_x     ($signed(b_pre_x)),
      .in_pre_y     ($signed(b_pre_y)),
      .in_pre_turn  ($signed(b_pre_turn)),
      .max_linear   (max_linear_ff),
      .rsp_valid    (rsp_valid),
      .rsp_sat_x    (rsp_sat_x),
      .rsp_sat_y    (rsp_sat_y),
      .rsp_sat_turn (rsp_sat_turn)
   );

endmodule

FILE: verif/planar_velocity_saturator_unit_tb.sv
// ----------------------------------------------------------------------------
// planar_velocity_saturator_unit_tb
// Self-checking bench for the planar velocity saturator. A queue-fed driver
// issues commands under several sender idle rates and limit settings. A
// monitor checks every result strobe against a bit-accurate prediction of
// the ratio scaling and the clamps.
// ----------------------------------------------------------------------------
module planar_velocity_saturator_unit_tb;
   import pvs_pkg::*;

   localparam int VW          = 16;
   localparam int FRAC        = 16;
   localparam int LW          = PVS_CSR_WIDTH;
   localparam int LATENCY     = FRAC + 3;
   localparam int CYCLE_LIMIT = 100000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [VW-1:0] turn;
   } velocity_t;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 start        = 1'b0;
   logic                 busy;
   logic signed [VW-1:0] req_vel_x    = '0;
   logic signed [VW-1:0] req_vel_y    = '0;
   logic signed [VW-1:0] req_vel_turn = '0;
   logic                 rsp_valid;
   logic signed [VW-1:0] rsp_sat_x;
   logic signed [VW-1:0] rsp_sat_y;
   logic signed [VW-1:0] rsp_sat_turn;
   logic                 csr_valid    = 1'b0;
   logic                 csr_ready;
   pvs_csr_idx_type      csr_index    = CSR_MAX_LINEAR;
   logic [LW-1:0]        csr_wdata    = '0;

   velocity_t     pending_cmds[$];
   velocity_t     expected_sat[$];
   velocity_t     observed;
   velocity_t     wanted;
   logic [LW-1:0] linear_limit  = LW'(PVS_HARD_LIMIT_INT << PVS_Q_FRAC_BITS);
   logic [LW-1:0] angular_limit = LW'(PVS_HARD_LIMIT_INT << PVS_Q_FRAC_BITS);
   int            idle_pct      = 0;
   int            mismatches    = 0;
   int            cycles        = 0;

   planar_velocity_saturator_unit #(
      .VEL_WIDTH       (VW),
      .RATIO_FRAC_BITS (FRAC)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_vel_x    (req_vel_x),
      .req_vel_y    (req_vel_y),
      .req_vel_turn (req_vel_turn),
      .rsp_valid    (rsp_valid),
      .rsp_sat_x    (rsp_sat_x),
      .rsp_sat_y    (rsp_sat_y),
      .rsp_sat_turn (rsp_sat_turn),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Magnitude of a two's complement value; the most negative one gives 2^(VW-1)
   function automatic logic [VW:0] magnitude(logic [VW-1:0] v);
      logic [VW:0] m;
      m = {1'b0, v};
      if (v[VW-1]) m = {1'b1, {VW{1'b0}}} - m;
      return m;
   endfunction

   // Clamp one axis to +/- lim, then scale by the ratio when it is the minor axis
   function automatic logic [VW-1:0] clamp_axis(logic [VW-1:0] raw, logic [LW-1:0] lim,
                                                bit scale, logic [63:0] ratio);
      logic [63:0]   prod;
      logic [VW-1:0] r;
      if (magnitude(raw) <= lim) return raw;
      prod = lim;
      if (scale) prod = (prod * ratio) >> FRAC;
      r = prod[VW-1:0];
      if (raw[VW-1]) r = -r;
      return r;
   endfunction

   function automatic velocity_t predict_saturation(velocity_t c);
      logic [63:0] ax;
      logic [63:0] ay;
      logic [63:0] ratio;
      bit          x_major;
      velocity_t   s;
      ax = magnitude(c.x);
      ay = magnitude(c.y);
      x_major = ax > ay;
      // On a tie y is the major axis and, unless both are zero, the ratio is exactly one
      if (x_major) ratio = (ay << FRAC) / ax;
      else if (ay != 0) ratio = (ax << FRAC) / ay;
      else ratio = '0;
      s.x    = clamp_axis(c.x, linear_limit, !x_major, ratio);
      s.y    = clamp_axis(c.y, linear_limit, x_major, ratio);
      s.turn = clamp_axis(c.turn, angular_limit, 1'b0, '0);
      return s;
   endfunction

   // Driver: hold the command while busy, otherwise advance or idle at random
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else begin
         if (start) begin
            expected_sat.push_back(predict_saturation({req_vel_x, req_vel_y, req_vel_turn}));
            void'(pending_cmds.pop_front());
         end
         if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            start        <= 1'b1;
            req_vel_x    <= pending_cmds[0].x;
            req_vel_y    <= pending_cmds[0].y;
            req_vel_turn <= pending_cmds[0].turn;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobe is a transfer, compare against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         observed = {rsp_sat_x, rsp_sat_y, rsp_sat_turn};
         if (expected_sat.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result x=%0d y=%0d turn=%0d",
                        observed.x, observed.y, observed.turn);
         end else begin
            wanted = expected_sat.pop_front();
            if (observed.x !== wanted.x || observed.y !== wanted.y ||
                observed.turn !== wanted.turn) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch: expected x=%0d y=%0d turn=%0d, got x=%0d y=%0d turn=%0d",
                           wanted.x, wanted.y, wanted.turn,
                           observed.x, observed.y, observed.turn);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic queue_cmd(int x, int y, int turn);
      velocity_t c;
      c.x    = x[VW-1:0];
      c.y    = y[VW-1:0];
      c.turn = turn[VW-1:0];
      pending_cmds.push_back(c);
   endtask

   // Bias values toward the limit, the extremes and the range around the limit
   function automatic logic [VW-1:0] pick_velocity(logic [LW-1:0] lim);
      int v;
      case ($urandom_range(0, 5))
         2: v = int'(lim) + $urandom_range(0, 4) - 2;
         3: v = $urandom_range(0, 2 * int'(lim) + 16);
         4: begin
            case ($urandom_range(0, 4))
               0: v = -32768;
               1: v = 32767;
               2: v = 0;
               3: v = -1;
               default: v = 1;
            endcase
         end
         default: v = $urandom;
      endcase
      if ($urandom_range(0, 1)) v = -v;
      return v[VW-1:0];
   endfunction

   task automatic queue_random(int count);
      velocity_t c;
      repeat (count) begin
         c.x    = pick_velocity(linear_limit);
         c.y    = pick_velocity(linear_limit);
         c.turn = pick_velocity(angular_limit);
         // Equal magnitudes now and then
         if ($urandom_range(0, 7) == 0) c.y = $urandom_range(0, 1) ? c.x : -c.x;
         pending_cmds.push_back(c);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || expected_sat.size() != 0 || start);
      repeat (LATENCY) @(negedge clock);
   endtask

   task automatic write_limit(pvs_csr_idx_type idx, logic [LW-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      if (idx == CSR_MAX_LINEAR) linear_limit = value;
      else angular_limit = value;
      csr_valid <= 1'b0;
   endtask

   task automatic set_limits(logic [LW-1:0] lin, logic [LW-1:0] ang, int idle);
      wait_drained();
      write_limit(CSR_MAX_LINEAR, lin);
      write_limit(CSR_MAX_ANGULAR, ang);
      @(negedge clock);
      idle_pct = idle;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset limits (2.0): zero, ties, extremes, minor axis scaling, symmetry
      idle_pct = 0;
      queue_cmd(0, 0, 0);
      queue_cmd(32767, 32767, 32767);
      queue_cmd(-32768, -32768, -32768);
      queue_cmd(-32768, 32767, 0);
      queue_cmd(32767, -32768, -32768);
      queue_cmd(1000, 1000, -1000);
      queue_cmd(-1000, 1000, 513);
      queue_cmd(1000, 700, 512);
      queue_cmd(1000, -700, -512);
      queue_cmd(700, -1000, -513);
      queue_cmd(-700, 1000, 1);
      queue_cmd(600, 300, -1);
      queue_cmd(512, 512, 512);
      queue_cmd(513, -513, -512);
      queue_cmd(-1, 1, -1);
      queue_cmd(1234, 0, 20000);
      queue_cmd(0, -5000, -20000);
      queue_cmd(3, 32767, 100);
      queue_cmd(32767, 32766, -100);
      queue_cmd(-32767, 32767, 32767);
      queue_random(60);

      // Zero limits: every nonzero value collapses to zero
      set_limits('0, '0, 70);
      queue_cmd(1, -1, 1);
      queue_cmd(0, 0, 0);
      queue_cmd(-32768, 5, -1);
      queue_random(40);

      set_limits({LW{1'b1}}, {LW{1'b1}}, 35);
      queue_random(60);

      set_limits(LW'($urandom_range(0, 32767)), LW'($urandom_range(0, 32767)), 0);
      queue_random(80);

      set_limits(LW'(512), LW'(1), 70);
      queue_random(70);

      set_limits(LW'($urandom_range(1, 4096)), LW'($urandom_range(0, 32767)), 35);
      queue_random(80);

      set_limits({LW{1'b1}}, '0, 0);
      queue_random(60);

      wait_drained();
      repeat (LATENCY) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
